@@ hdl/sts_pkg.sv @@
// Shared types and constants of the sparse ternary index sampler.
// Used by the front end, the group queue, the back end and the top level.
// Depends on nothing.
package sts_pkg;

	localparam int MAX_DEGREE  = 1024;
	localparam int INDEX_BYTES = 8;
	localparam int MAX_WEIGHT  = 64;

	localparam int SIGN_DEPTH = MAX_WEIGHT / 8 + 1;

	localparam int DEG_W     = 11;                          // poly_degree register width
	localparam int WRAW_W    = 7;                           // encoding_weight register width
	localparam int COEF_W    = $clog2(MAX_DEGREE);          // coefficient index width
	localparam int PLACE_W   = $clog2(MAX_WEIGHT + 1);      // placement counter width
	localparam int SADDR_W   = $clog2(SIGN_DEPTH);          // sign byte address width
	localparam int SEEN_W    = $clog2(SIGN_DEPTH + 1);      // sign byte counter width
	localparam int IDX_W     = INDEX_BYTES * 8;             // one index group in bits
	localparam int CNT_W     = $clog2(INDEX_BYTES + 1);     // byte counter within a group
	localparam int QDEPTH    = 4;                           // group queue depth
	localparam int QADDR_W   = $clog2(QDEPTH);
	localparam int INFL_W    = $clog2(QDEPTH + 2);          // groups queued or in the back end
	localparam int EPOCH_W   = 6;                           // occupancy map epoch tag
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = DEG_W;
	localparam int OUT_W     = ((COEF_W + 1 + 7) / 8) * 8;  // output tdata width

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEGREE = 1'b0,
		REG_WEIGHT = 1'b1
	} reg_idx_t;

	// Effective configuration, already clamped.
	typedef struct packed {
		logic [DEG_W-1:0]   degree;
		logic [PLACE_W-1:0] weight;
		logic [SEEN_W-1:0]  sign_total;
	} cfg_t;

	// Front end to back end.
	typedef struct packed {
		logic               clear;
		logic               sign_we;
		logic [SADDR_W-1:0] sign_addr;
		logic [7:0]         sign_data;
	} fr_ctrl_t;

	// Back end to front end.
	typedef struct packed {
		logic               sweeping;
		logic               group_done;
		logic [PLACE_W-1:0] placed;
	} bk_status_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_MOD,
		ST_LOOK,
		ST_CHECK
	} bk_state_t;

endpackage

@@ hdl/sparse_ternary_index_sampler.sv @@
// Top level of the sparse ternary index sampler: configuration registers
// and the wiring of front end, group queue and back end. Depends on sts_pkg.

// The sampler takes one keystream byte per item on the s_axis side; tuser
// set on an item starts a new encoding and that byte is its first. The first
// weight/8+1 bytes of an encoding are kept as sign bits, and every following
// group of eight bytes is read as a big-endian 64-bit value and reduced
// modulo the degree. A free index comes out on m_axis with its sign, and the
// weight-th placement carries tlast; later bytes are accepted and dropped
// until the next start. Sign bytes and the bytes of a group are taken one
// per cycle while the front end is ready. The back end takes each group
// through a load, a byte-per-cycle modulo reduction, an occupancy map read
// and a step that checks, marks and emits. While its four-entry group queue
// has room, the front end goes on taking index bytes as earlier groups
// are still worked on. Near the end of an encoding the front end holds
// bytes until the back end has settled whether the encoding is complete,
// and a start item waits until all queued groups are finished. The
// occupancy map is an epoch-tagged memory: after reset, and after every
// 63rd start, a clearing pass runs through it, during which no item is
// accepted. Configuration writes are taken in any cycle and are meant for
// an idle block.
module sparse_ternary_index_sampler (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           cfg_we,
	input  logic [sts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sts_pkg::CFG_DAT_W-1:0]  cfg_data,
	// keystream items
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,   // [7:0] random_byte
	input  logic                           s_axis_tuser,   // [0] start_req
	// placed coefficients
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [sts_pkg::OUT_W-1:0]      m_axis_tdata,   // [9:0] coeff_index, [10] coeff_positive
	output logic                           m_axis_tlast    // last
);

	logic [sts_pkg::DEG_W-1:0]  degree_q;
	logic [sts_pkg::WRAW_W-1:0] weight_q;

	sts_pkg::cfg_t       cfg;
	sts_pkg::fr_ctrl_t   ctl;
	sts_pkg::bk_status_t st;

	logic                      q_push;
	logic [sts_pkg::IDX_W-1:0] q_push_data;
	logic                      q_pop;
	logic [sts_pkg::IDX_W-1:0] q_pop_data;
	logic                      q_full;
	logic                      q_empty;

	logic [sts_pkg::DEG_W-1:0]  deg_eff;
	logic [sts_pkg::WRAW_W-1:0] w_lo;
	logic [sts_pkg::DEG_W-1:0]  w_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= sts_pkg::DEG_W'(1024);
			weight_q <= sts_pkg::WRAW_W'(32);
		end else if (cfg_we) begin
			case (sts_pkg::reg_idx_t'(cfg_index))
				sts_pkg::REG_DEGREE: degree_q <= cfg_data;
				sts_pkg::REG_WEIGHT: weight_q <= cfg_data[sts_pkg::WRAW_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the registers: a zero degree or weight acts as one, both are
	// capped at their maxima, and the weight never exceeds the degree.
	always_comb begin
		deg_eff = degree_q;
		if (deg_eff == '0) begin
			deg_eff = sts_pkg::DEG_W'(1);
		end
		if (deg_eff > sts_pkg::DEG_W'(sts_pkg::MAX_DEGREE)) begin
			deg_eff = sts_pkg::DEG_W'(sts_pkg::MAX_DEGREE);
		end

		w_lo = weight_q;
		if (w_lo == '0) begin
			w_lo = sts_pkg::WRAW_W'(1);
		end
		if (w_lo > sts_pkg::WRAW_W'(sts_pkg::MAX_WEIGHT)) begin
			w_lo = sts_pkg::WRAW_W'(sts_pkg::MAX_WEIGHT);
		end
		w_mid = sts_pkg::DEG_W'(w_lo);
		if (w_mid > deg_eff) begin
			w_mid = deg_eff;
		end

		cfg.degree     = deg_eff;
		cfg.weight     = sts_pkg::PLACE_W'(w_mid);
		cfg.sign_total = sts_pkg::SEEN_W'((w_mid >> 3) + 1'b1);
	end

	sts_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg           (cfg),
		.st            (st),
		.ctl           (ctl),
		.q_push        (q_push),
		.q_data        (q_push_data),
		.q_full        (q_full)
	);

	sts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	sts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.ctl           (ctl),
		.st            (st),
		.q_pop         (q_pop),
		.q_data        (q_pop_data),
		.q_empty       (q_empty),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ hdl/sts_queue.sv @@
// Short queue of completed index groups between the front and back ends.
// Depends on sts_pkg.
module sts_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [sts_pkg::IDX_W-1:0] push_data,
	input  logic                      pop,
	output logic [sts_pkg::IDX_W-1:0] pop_data,
	output logic                      full,
	output logic                      empty
);

	logic [sts_pkg::IDX_W-1:0]   entry_q [sts_pkg::QDEPTH];
	logic [sts_pkg::QADDR_W-1:0] wr_ptr_q;
	logic [sts_pkg::QADDR_W-1:0] rd_ptr_q;
	logic [sts_pkg::QADDR_W:0]   count_q;

	assign full     = (count_q == (sts_pkg::QADDR_W + 1)'(sts_pkg::QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == sts_pkg::QADDR_W'(sts_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == sts_pkg::QADDR_W'(sts_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (sts_pkg::QADDR_W + 1)'(push) -
				(sts_pkg::QADDR_W + 1)'(pop);
		end
	end

endmodule

@@ hdl/sts_front.sv @@
// Front end: accepts keystream bytes, handles start, routes sign bytes and
// packs index groups into the queue. Depends on sts_pkg.
module sts_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,
	input  logic                       s_axis_tuser,
	input  sts_pkg::cfg_t              cfg,
	input  sts_pkg::bk_status_t        st,
	output sts_pkg::fr_ctrl_t          ctl,
	output logic                       q_push,
	output logic [sts_pkg::IDX_W-1:0]  q_data,
	input  logic                       q_full
);

	logic [sts_pkg::SEEN_W-1:0]  seen_q;
	logic [sts_pkg::CNT_W-1:0]   cnt_q;
	logic [sts_pkg::IDX_W-1:0]   acc_q;
	logic [sts_pkg::INFL_W-1:0]  inflight_q;

	logic [sts_pkg::SEEN_W-1:0]  seen_e;
	logic [sts_pkg::CNT_W-1:0]   cnt_e;
	logic [sts_pkg::IDX_W-1:0]   acc_e;
	logic                        in_sign;
	logic                        completing;
	logic [sts_pkg::PLACE_W:0]   promised;
	logic                        not_done;
	logic                        done_known;
	logic                        take;
	logic                        act;

	always_comb begin
		seen_e     = s_axis_tuser ? '0 : seen_q;
		cnt_e      = s_axis_tuser ? '0 : cnt_q;
		acc_e      = s_axis_tuser ? '0 : acc_q;
		in_sign    = (seen_e < cfg.sign_total);
		completing = !in_sign && (cnt_e == sts_pkg::CNT_W'(sts_pkg::INDEX_BYTES - 1));

		// Every queued group may still place, so the encoding is certainly
		// open while the promised total stays below the weight.
		promised   = (sts_pkg::PLACE_W + 1)'(st.placed) +
			(sts_pkg::PLACE_W + 1)'(inflight_q);
		not_done   = (promised < (sts_pkg::PLACE_W + 1)'(cfg.weight));
		done_known = (inflight_q == '0) && (st.placed >= cfg.weight);

		if (s_axis_tuser) begin
			s_axis_tready = !st.sweeping && (inflight_q == '0);
		end else begin
			s_axis_tready = !st.sweeping &&
				(done_known || (not_done && !(completing && q_full)));
		end

		take = s_axis_tvalid && s_axis_tready;
		act  = take && (s_axis_tuser || !done_known);

		ctl.clear     = take && s_axis_tuser;
		ctl.sign_we   = act && in_sign;
		ctl.sign_addr = seen_e[sts_pkg::SADDR_W-1:0];
		ctl.sign_data = s_axis_tdata;

		q_push = act && completing;
		q_data = (acc_e << 8) | sts_pkg::IDX_W'(s_axis_tdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			cnt_q      <= '0;
			acc_q      <= '0;
			inflight_q <= '0;
		end else begin
			if (act) begin
				if (in_sign) begin
					seen_q <= seen_e + 1'b1;
					cnt_q  <= cnt_e;
					acc_q  <= acc_e;
				end else if (completing) begin
					seen_q <= seen_e;
					cnt_q  <= '0;
					acc_q  <= '0;
				end else begin
					seen_q <= seen_e;
					cnt_q  <= cnt_e + 1'b1;
					acc_q  <= (acc_e << 8) | sts_pkg::IDX_W'(s_axis_tdata);
				end
			end
			inflight_q <= inflight_q + sts_pkg::INFL_W'(q_push) -
				sts_pkg::INFL_W'(st.group_done);
		end
	end

	a_done_has_group: assert property (@(posedge clk) disable iff (!arst_n)
		st.group_done |-> inflight_q != '0)
		else $error("group finished with no group outstanding");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("group pushed into a full queue");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= sts_pkg::INFL_W'(sts_pkg::QDEPTH + 1))
		else $error("outstanding group count beyond queue and back end");

endmodule

@@ hdl/sts_back.sv @@
// Back end: reduces each index group modulo the degree a byte per cycle,
// checks and marks the epoch-tagged occupancy map, and drives the output
// register. Depends on sts_pkg.
module sts_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sts_pkg::cfg_t              cfg,
	input  sts_pkg::fr_ctrl_t          ctl,
	output sts_pkg::bk_status_t        st,
	output logic                       q_pop,
	input  logic [sts_pkg::IDX_W-1:0]  q_data,
	input  logic                       q_empty,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [sts_pkg::OUT_W-1:0]  m_axis_tdata,
	output logic                       m_axis_tlast
);

	// One byte of restoring reduction: eight shift and conditional subtract
	// steps on a remainder that stays below the degree.
	function automatic logic [sts_pkg::DEG_W-1:0] mod_byte(
		input logic [sts_pkg::DEG_W-1:0] r,
		input logic [7:0]                b,
		input logic [sts_pkg::DEG_W-1:0] n
	);
		logic [sts_pkg::DEG_W-1:0] t;
		t = r;
		for (int i = 7; i >= 0; i--) begin
			t = {t[sts_pkg::DEG_W-2:0], b[i]};
			if (t >= n) begin
				t = t - n;
			end
		end
		return t;
	endfunction

	sts_pkg::bk_state_t state_q, state_d;

	logic [sts_pkg::EPOCH_W-1:0] map_mem [sts_pkg::MAX_DEGREE];
	logic [sts_pkg::EPOCH_W-1:0] rd_q;
	logic [7:0]                  sign_q [sts_pkg::SIGN_DEPTH];

	logic [sts_pkg::IDX_W-1:0]   sh_q;
	logic [sts_pkg::DEG_W-1:0]   r_q;
	logic [sts_pkg::CNT_W-1:0]   cnt_q;
	logic [sts_pkg::COEF_W-1:0]  sweep_q;
	logic [sts_pkg::EPOCH_W-1:0] epoch_q;
	logic [sts_pkg::PLACE_W-1:0] placed_q;

	logic                        out_valid_q;
	logic [sts_pkg::COEF_W-1:0]  out_idx_q;
	logic                        out_pos_q;
	logic                        out_last_q;

	logic                        slot_free;
	logic                        occupied;
	logic                        place;
	logic                        sweep_end;
	logic                        mod_end;
	logic                        mem_we;
	logic [sts_pkg::COEF_W-1:0]  mem_waddr;
	logic [sts_pkg::EPOCH_W-1:0] mem_wdata;
	logic [sts_pkg::PLACE_W-1:0] placed_inc;
	logic [7:0]                  sign_byte;

	assign slot_free  = !out_valid_q || m_axis_tready;
	assign occupied   = (rd_q == epoch_q);
	assign sweep_end  = (sweep_q == sts_pkg::COEF_W'(sts_pkg::MAX_DEGREE - 1));
	assign mod_end    = (cnt_q == sts_pkg::CNT_W'(sts_pkg::INDEX_BYTES - 1));
	assign placed_inc = placed_q + 1'b1;
	assign sign_byte  = sign_q[sts_pkg::SADDR_W'(placed_q >> 3)];

	always_comb begin
		state_d       = state_q;
		q_pop         = 1'b0;
		place         = 1'b0;
		st.group_done = 1'b0;
		case (state_q)
			sts_pkg::ST_SWEEP: begin
				if (sweep_end) begin
					state_d = sts_pkg::ST_IDLE;
				end
			end
			sts_pkg::ST_IDLE: begin
				if (ctl.clear && (epoch_q == '1)) begin
					state_d = sts_pkg::ST_SWEEP;
				end else if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = sts_pkg::ST_MOD;
				end
			end
			sts_pkg::ST_MOD: begin
				if (mod_end) begin
					state_d = sts_pkg::ST_LOOK;
				end
			end
			sts_pkg::ST_LOOK: begin
				state_d = sts_pkg::ST_CHECK;
			end
			sts_pkg::ST_CHECK: begin
				if (occupied) begin
					st.group_done = 1'b1;
					state_d       = sts_pkg::ST_IDLE;
				end else if (slot_free) begin
					place         = 1'b1;
					st.group_done = 1'b1;
					state_d       = sts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sts_pkg::ST_SWEEP;
			end
		endcase

		mem_we    = (state_q == sts_pkg::ST_SWEEP) || place;
		mem_waddr = (state_q == sts_pkg::ST_SWEEP) ? sweep_q : r_q[sts_pkg::COEF_W-1:0];
		mem_wdata = (state_q == sts_pkg::ST_SWEEP) ? '0 : epoch_q;

		st.sweeping = (state_q == sts_pkg::ST_SWEEP);
		st.placed   = placed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sts_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= map_mem[r_q[sts_pkg::COEF_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.sign_we) begin
			sign_q[ctl.sign_addr] <= ctl.sign_data;
		end
		if (q_pop) begin
			sh_q  <= q_data;
			r_q   <= '0;
			cnt_q <= '0;
		end else if (state_q == sts_pkg::ST_MOD) begin
			r_q   <= mod_byte(r_q, sh_q[sts_pkg::IDX_W-1 -: 8], cfg.degree);
			sh_q  <= sh_q << 8;
			cnt_q <= cnt_q + 1'b1;
		end
		if (place) begin
			out_idx_q  <= r_q[sts_pkg::COEF_W-1:0];
			out_pos_q  <= sign_byte[placed_q[2:0]];
			out_last_q <= (placed_inc >= cfg.weight);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			epoch_q     <= sts_pkg::EPOCH_W'(1);
			placed_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == sts_pkg::ST_SWEEP) begin
				sweep_q <= sweep_end ? '0 : sweep_q + 1'b1;
			end
			if (ctl.clear) begin
				placed_q <= '0;
				epoch_q  <= (epoch_q == '1) ? sts_pkg::EPOCH_W'(1) : epoch_q + 1'b1;
			end else if (place) begin
				placed_q <= placed_inc;
			end
			if (place) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = sts_pkg::OUT_W'({out_pos_q, out_idx_q});

	a_clear_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |-> (state_q == sts_pkg::ST_IDLE) && q_empty)
		else $error("start taken while index groups are outstanding");

	a_place_below_weight: assert property (@(posedge clk) disable iff (!arst_n)
		place |-> placed_q < cfg.weight)
		else $error("placement beyond the encoding weight");

endmodule

@@ tb/tb_sparse_ternary_index_sampler.sv @@
// Self-checking testbench for the sparse ternary index sampler.
// It drives keystream bytes and register writes, predicts every placed coefficient
// and compares it with the m_axis output. Depends on sts_pkg and the sampler RTL.
`timescale 1ns / 100ps

module tb_sparse_ternary_index_sampler;
	import sts_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 950;
	// Long enough for the queued groups to drain and for the map clearing pass
	// that follows reset and every 63rd start.
	localparam int unsigned SETTLE_CYCLES = 1100;
	localparam int unsigned DRAIN_CYCLES  = 100;
	localparam int unsigned CYCLE_LIMIT   = 1000000;

	// One placed coefficient as it leaves the block.
	typedef struct packed {
		logic [COEF_W-1:0] slot;
		logic              plus;
		logic              closing;
	} coeff_t;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_SET_DEGREE,
		ROW_SET_WEIGHT
	} row_kind_t;

	// One row of the directed table. For a register row only value counts.
	typedef struct packed {
		row_kind_t          kind;
		logic [CFG_DAT_W-1:0] value;
		logic               start;
		logic               typed;
		coeff_t             want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;   // [7:0] random_byte
	logic                 s_axis_tuser;   // [0] start_req
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;   // [9:0] coeff_index, [10] coeff_positive
	logic                 m_axis_tlast;   // last

	sparse_ternary_index_sampler uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Predictor state. The map and the counters start cleared, as after reset;
	// the sign store stays unknown until a sign byte is written.
	bit                   occupied [MAX_DEGREE];
	logic [7:0]           sign_store [SIGN_DEPTH];
	int unsigned          signs_taken = 0;
	int unsigned          group_fill = 0;
	int unsigned          placements = 0;
	bit [IDX_W-1:0]       group_value = '0;
	logic [CFG_DAT_W-1:0] reg_degree = 11'd1024;
	logic [WRAW_W-1:0]    reg_weight = 7'd32;

	coeff_t      expected_coeffs [$];
	plan_row_t   directed_plan [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned live_items = 0;
	bit          no_gaps = 1'b0;
	// Set once an item went in since the block was last known to be idle.
	bit          dirty = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Degree and weight as the block applies them: zero acts as one, values above
	// the maximum act as the maximum, and the weight never exceeds the degree.
	function automatic int unsigned active_degree();
		int unsigned n;
		n = reg_degree;
		if (n == 0) n = 1;
		if (n > MAX_DEGREE) n = MAX_DEGREE;
		return n;
	endfunction

	function automatic int unsigned active_weight();
		int unsigned w;
		int unsigned n;
		n = active_degree();
		w = reg_weight;
		if (w == 0) w = 1;
		if (w > MAX_WEIGHT) w = MAX_WEIGHT;
		if (w > n) w = n;
		return w;
	endfunction

	// Advances the predictor by one accepted keystream byte. produced tells
	// whether a coefficient is placed, dropped whether the byte arrived after
	// the encoding was already complete.
	task automatic predict_byte(input logic [7:0] b, input logic st,
			output logic produced, output logic dropped, output coeff_t c);
		int unsigned w;
		logic [COEF_W-1:0] pick;
		produced = 1'b0;
		dropped = 1'b0;
		c = '0;
		if (st) begin
			foreach (occupied[i]) occupied[i] = 1'b0;
			signs_taken = 0;
			group_fill = 0;
			placements = 0;
			group_value = '0;
		end
		w = active_weight();
		if (placements >= w) begin
			dropped = 1'b1;
		end else if (signs_taken < w / 8 + 1) begin
			if (signs_taken < SIGN_DEPTH) sign_store[signs_taken] = b;
			signs_taken++;
		end else begin
			// Index bytes arrive most significant first.
			group_value = {group_value[IDX_W-9:0], b};
			group_fill++;
			if (group_fill == INDEX_BYTES) begin
				pick = COEF_W'(group_value % 64'(active_degree()));
				group_value = '0;
				group_fill = 0;
				// An index that is already taken is skipped without a result.
				if (!occupied[pick]) begin
					occupied[pick] = 1'b1;
					c.slot = pick;
					c.plus = sign_store[placements / 8][placements % 8];
					placements++;
					c.closing = placements >= w;
					produced = 1'b1;
				end
			end
		end
	endtask

	// Offers one byte, waits for it to be taken and records what it must cause.
	// Starts and ends at a falling edge. With typed set, want replaces the
	// predicted coefficient.
	task automatic push_byte(input logic [7:0] b, input logic st, input logic typed,
			input coeff_t want);
		logic   produced;
		logic   dropped;
		coeff_t predicted;
		no_gaps = live_items >= 300 && live_items < 450;
		while (!no_gaps && $urandom_range(99) < 21) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= st;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_byte(b, st, produced, dropped, predicted);
		if (produced) expected_coeffs.push_back(typed ? want : predicted);
		if (!dropped) live_items++;
		dirty = 1'b1;
		@(negedge clk);
	endtask

	// Holds the sender until every expected coefficient is out, then lets the
	// back end finish any group that places nothing.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		if (dirty) begin
			while (expected_coeffs.size() != 0) @(negedge clk);
			repeat (SETTLE_CYCLES) @(negedge clk);
			dirty = 1'b0;
		end
	endtask

	task automatic set_register(input reg_idx_t which, input logic [CFG_DAT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		if (which == REG_DEGREE) reg_degree = value;
		else reg_weight = value[WRAW_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_row(input row_kind_t kind, input int unsigned value, input logic st,
			input logic typed, input coeff_t want);
		plan_row_t row;
		row.kind  = kind;
		row.value = CFG_DAT_W'(value);
		row.start = st;
		row.typed = typed;
		row.want  = want;
		directed_plan.push_back(row);
	endtask

	// One encoding of random content. It opens with a start unless it carries
	// on the open encoding under new settings, stops when the encoding is
	// complete, the byte cap is hit or the random item budget is spent, and
	// may add up to two more bytes, which are dropped if the encoding is complete.
	task automatic run_encoding(input logic open_new, input int unsigned byte_cap,
			input logic allow_noise);
		int unsigned sent;
		logic        st;
		sent = 0;
		if (open_new) begin
			push_byte(8'($urandom_range(255)), 1'b1, 1'b0, '0);
			sent = 1;
		end
		while (placements < active_weight() && sent < byte_cap &&
				live_items < RANDOM_ITEMS) begin
			// Now and then a stray start breaks the sequence.
			st = allow_noise && $urandom_range(99) < 2;
			push_byte(8'($urandom_range(255)), st, 1'b0, '0);
			sent++;
		end
		repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
	endtask

	// The receiver stalls at random except during the stretch without gaps.
	always @(negedge clk) begin
		m_axis_tready <= no_gaps || $urandom_range(99) >= 21;
	end

	// Every coefficient taken from the block is matched with the oldest
	// expectation, field by field.
	always @(posedge clk) begin : check_coeffs
		coeff_t got;
		coeff_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.slot    = m_axis_tdata[COEF_W-1:0];
			got.plus    = m_axis_tdata[COEF_W];
			got.closing = m_axis_tlast;
			if (expected_coeffs.size() == 0) begin
				mismatch_count++;
				$display("%0t: expected no coefficient, got index %0d sign %0b last %0b",
					$time, got.slot, got.plus, got.closing);
			end else begin
				want = expected_coeffs.pop_front();
				if (got.slot !== want.slot) begin
					mismatch_count++;
					$display("%0t: coeff_index expected %0d, got %0d",
						$time, want.slot, got.slot);
				end
				if (got.plus !== want.plus) begin
					mismatch_count++;
					$display("%0t: coeff_positive expected %0b, got %0b",
						$time, want.plus, got.plus);
				end
				if (got.closing !== want.closing) begin
					mismatch_count++;
					$display("%0t: last expected %0b, got %0b",
						$time, want.closing, got.closing);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		plan_row_t   row;
		bit          first;
		bit          resume;
		int unsigned pick;
		int unsigned encodings;
		int unsigned cap;
		logic [CFG_DAT_W-1:0] degree_value;
		logic [CFG_DAT_W-1:0] weight_value;

		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_DEGREE;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;

		// Degree above the maximum acts as 1024 and weight one needs a single
		// sign byte. Eight all-ones bytes reduce to the top index 1023, with a
		// positive sign, and close the encoding; the byte after is dropped.
		add_row(ROW_SET_DEGREE, 2047, 1'b0, 1'b0, '0);
		add_row(ROW_SET_WEIGHT, 1, 1'b0, 1'b0, '0);
		add_row(ROW_ITEM, 8'h01, 1'b1, 1'b0, '0);
		repeat (7) add_row(ROW_ITEM, 8'hFF, 1'b0, 1'b0, '0);
		add_row(ROW_ITEM, 8'hFF, 1'b0, 1'b1, {10'd1023, 1'b1, 1'b1});
		add_row(ROW_ITEM, 8'h5A, 1'b0, 1'b0, '0);
		// Degree zero acts as one and weight zero as one: any group lands on
		// index 0, and sign bit 0 of 0xFE gives a negative coefficient.
		add_row(ROW_SET_DEGREE, 0, 1'b0, 1'b0, '0);
		add_row(ROW_SET_WEIGHT, 0, 1'b0, 1'b0, '0);
		add_row(ROW_ITEM, 8'hFE, 1'b1, 1'b0, '0);
		add_row(ROW_ITEM, 8'h80, 1'b0, 1'b0, '0);
		repeat (6) add_row(ROW_ITEM, 8'h00, 1'b0, 1'b0, '0);
		add_row(ROW_ITEM, 8'h00, 1'b0, 1'b1, {10'd0, 1'b0, 1'b1});

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			case (row.kind)
				ROW_SET_DEGREE: begin
					wait_idle();
					set_register(REG_DEGREE, row.value);
				end
				ROW_SET_WEIGHT: begin
					wait_idle();
					set_register(REG_WEIGHT, row.value);
				end
				default: begin
					push_byte(row.value[7:0], row.start, row.typed, row.want);
				end
			endcase
		end

		// Random phases. The first one runs a full weight-64 encoding, which
		// also writes all nine sign bytes; only after that may a phase carry on
		// an open encoding under changed settings, weight raises included.
		live_items = 0;
		first = 1'b1;
		while (live_items < RANDOM_ITEMS) begin
			wait_idle();
			if (first) begin
				set_register(REG_DEGREE, 11'd1024);
				set_register(REG_WEIGHT, 11'd64);
			end else begin
				case ($urandom_range(7))
					0: degree_value = 11'd1;
					1: degree_value = 11'd0;
					2: degree_value = 11'd2047;
					3: degree_value = 11'd1024;
					4: degree_value = 11'($urandom_range(2, 16));
					5: degree_value = 11'($urandom_range(1025, 2046));
					default: degree_value = 11'($urandom_range(17, 1023));
				endcase
				case ($urandom_range(6))
					0: weight_value = 11'd0;
					1: weight_value = 11'd127;
					2: weight_value = 11'd64;
					3: weight_value = 11'd1;
					default: weight_value = 11'($urandom_range(2, 20));
				endcase
				pick = $urandom_range(3);
				if (pick != 1) set_register(REG_DEGREE, degree_value);
				if (pick != 2) set_register(REG_WEIGHT, weight_value);
			end
			encodings = first ? 1 : $urandom_range(1, 3);
			for (int e = 0; e < encodings; e++) begin
				resume = !first && e == 0 && $urandom_range(9) == 0;
				if (first) cap = 600;
				else if ($urandom_range(9) == 0) cap = $urandom_range(1, 40);
				else cap = 200;
				run_encoding(!resume, cap, !first);
			end
			first = 1'b0;
		end

		s_axis_tvalid <= 1'b0;
		while (expected_coeffs.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/sts_pkg.sv
hdl/sts_queue.sv
hdl/sts_front.sv
hdl/sts_back.sv
hdl/sparse_ternary_index_sampler.sv
tb/tb_sparse_ternary_index_sampler.sv
